/* hw/rtl/tsb_pkg.sv */
// Shared types and constants for the texture sampler.
`default_nettype none
package tsb_pkg;

  localparam int MAX_SIDE_DEF  = 256;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CHAN_W        = 16;
  localparam int TEXEL_W       = 4 * CHAN_W;
  localparam int ADDR_W        = 16;
  localparam int COORD_W       = 32;
  localparam int SIDE_REG_W    = 9;
  localparam int CFG_W         = 9;
  localparam int CFG_IDX_W     = 2;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH,
    REG_TEX_HEIGHT,
    REG_FILTER_MODE,
    REG_WRAP_MODE
  } cfg_reg_t;

  typedef logic [TEXEL_W-1:0] texel_t;

endpackage
`default_nettype wire

/* hw/rtl/tsb_bank.sv */
// One copy of the texel store: one write port, one registered read port.
`default_nettype none
module tsb_bank
  import tsb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire texel_t            wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output texel_t                 rdata
);

  texel_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/texture_sampler_bilinear_unit.sv */
// Top level of the texture sampler: coordinate pipeline, texel store and blend.
`default_nettype none
// The unit takes one transaction per clock cycle and never raises busy. A write
// transaction stores one texel; a sample transaction returns one texel on the out_
// ports with out_valid high for exactly one cycle. The result passes through the
// pipeline: coordinate normalization, scaling multiply, address multiply, the read
// of the texel store, and two blend multiply stages. The store is held in four
// identical copies, each written by every write, so the four texels of a bilinear
// footprint are read in a single cycle. Writes pass through the same coordinate
// and address stages as samples, so transactions take effect in order. The
// receiver must take every result; there is no back-pressure. Configuration may
// be written only while no transaction is in flight.
module texture_sampler_bilinear_unit
  import tsb_pkg::*;
#(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  cmd,
  input  wire logic [ADDR_W-1:0]     texel_index,
  input  wire logic [CHAN_W-1:0]     in_red,
  input  wire logic [CHAN_W-1:0]     in_green,
  input  wire logic [CHAN_W-1:0]     in_blue,
  input  wire logic [CHAN_W-1:0]     in_alpha,
  input  wire logic signed [COORD_W-1:0] coord_u,
  input  wire logic signed [COORD_W-1:0] coord_v,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  output logic                       out_valid,
  output logic [CHAN_W-1:0]          out_red,
  output logic [CHAN_W-1:0]          out_green,
  output logic [CHAN_W-1:0]          out_blue,
  output logic [CHAN_W-1:0]          out_alpha
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int N_W    = FRAC_BITS + 1;
  localparam int SU_W   = N_W + SIDE_W;
  localparam int PROD_W = (2 * SIDE_W + 1 > ADDR_W) ? 2 * SIDE_W + 1 : ADDR_W;
  localparam int R_W    = CHAN_W + FRAC_BITS + 1;
  localparam int ACC_W  = R_W + FRAC_BITS + 1;
  localparam logic [COORD_W-1:0] ONE_C  = COORD_W'(1) << FRAC_BITS;
  localparam logic [N_W-1:0]     ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  // Configuration registers.
  logic [SIDE_REG_W-1:0] tex_width;
  logic [SIDE_REG_W-1:0] tex_height;
  logic                  filter_mode;
  logic                  wrap_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width   <= SIDE_REG_W'(256);
      tex_height  <= SIDE_REG_W'(256);
      filter_mode <= 1'b0;
      wrap_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TEX_WIDTH:   tex_width   <= cfg_data[SIDE_REG_W-1:0];
        REG_TEX_HEIGHT:  tex_height  <= cfg_data[SIDE_REG_W-1:0];
        REG_FILTER_MODE: filter_mode <= cfg_data[0];
        REG_WRAP_MODE:   wrap_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_REG_W-1:0] r);
    logic [SIDE_W-1:0] s;
    if (r == '0) begin
      s = SIDE_W'(1);
    end else if (32'(r) > MAX_SIDE) begin
      s = SIDE_W'(MAX_SIDE);
    end else begin
      s = SIDE_W'(r);
    end
    return s;
  endfunction

  function automatic logic [N_W-1:0] norm_coord(input logic [COORD_W-1:0] raw,
                                                input logic wrap);
    logic [N_W-1:0] n;
    if (wrap) begin
      n = {1'b0, raw[FRAC_BITS-1:0]};
    end else if (raw[COORD_W-1]) begin
      n = '0;
    end else if (raw > ONE_C) begin
      n = ONE_FX;
    end else begin
      n = raw[N_W-1:0];
    end
    return n;
  endfunction

  logic [SIDE_W-1:0] w_side, h_side, w_m1, h_m1;
  assign w_side = side_of(tex_width);
  assign h_side = side_of(tex_height);
  assign w_m1   = w_side - SIDE_W'(1);
  assign h_m1   = h_side - SIDE_W'(1);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: normalized coordinates.
  logic              s1_valid, s1_sample;
  logic [N_W-1:0]    s1_nu, s1_nv;
  logic [ADDR_W-1:0] s1_index;
  texel_t            s1_texel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_sample <= (cmd == CMD_SAMPLE);
    s1_nu     <= norm_coord(coord_u, wrap_mode);
    s1_nv     <= norm_coord(coord_v, wrap_mode);
    s1_index  <= texel_index;
    s1_texel  <= {in_alpha, in_blue, in_green, in_red};
  end

  // Stage 2: scale by size minus one.
  logic              s2_valid, s2_sample;
  logic [SU_W-1:0]   s2_su, s2_sv;
  logic [ADDR_W-1:0] s2_index;
  texel_t            s2_texel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_sample <= s1_sample;
    s2_su     <= SU_W'(s1_nu) * SU_W'(w_m1);
    s2_sv     <= SU_W'(s1_nv) * SU_W'(h_m1);
    s2_index  <= s1_index;
    s2_texel  <= s1_texel;
  end

  // Stage 3: footprint addresses. Nearest mode points all four reads at the texel
  // of the truncated coordinate and blends with zero fractional weights.
  logic [SIDE_W-1:0]    x0, y0, x1, y1;
  logic [SIDE_W:0]      x0p, y0p;
  logic [FRAC_BITS-1:0] fx, fy;

  always_comb begin
    x0  = s2_su[FRAC_BITS +: SIDE_W];
    y0  = s2_sv[FRAC_BITS +: SIDE_W];
    x0p = {1'b0, x0} + (SIDE_W+1)'(1);
    y0p = {1'b0, y0} + (SIDE_W+1)'(1);
    x1  = (x0p < {1'b0, w_m1}) ? x0p[SIDE_W-1:0] : w_m1;
    y1  = (y0p < {1'b0, h_m1}) ? y0p[SIDE_W-1:0] : h_m1;
    if (!filter_mode) begin
      x1 = x0;
      y1 = y0;
    end
    fx  = filter_mode ? s2_su[FRAC_BITS-1:0] : '0;
    fy  = filter_mode ? s2_sv[FRAC_BITS-1:0] : '0;
  end

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SIDE_W-1:0] col,
                                                input logic [SIDE_W-1:0] row,
                                                input logic [SIDE_W-1:0] w);
    logic [PROD_W-1:0] p;
    p = PROD_W'(row) * PROD_W'(w) + PROD_W'(col);
    return p[ADDR_W-1:0];
  endfunction

  logic                 s3_valid, s3_sample;
  logic [ADDR_W-1:0]    s3_addr [4];
  logic [FRAC_BITS-1:0] s3_fx, s3_fy;
  logic [ADDR_W-1:0]    s3_index;
  texel_t               s3_texel;
  logic                 s3_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_sample  <= s2_sample;
    s3_addr[0] <= addr_of(x0, y0, w_side);
    s3_addr[1] <= addr_of(x1, y0, w_side);
    s3_addr[2] <= addr_of(x0, y1, w_side);
    s3_addr[3] <= addr_of(x1, y1, w_side);
    s3_fx      <= fx;
    s3_fy      <= fy;
    s3_index   <= s2_index;
    s3_texel   <= s2_texel;
  end

  assign s3_we = s3_valid && !s3_sample;

  // Stage 4: texel store read.
  texel_t               rd [4];
  logic                 s4_valid;
  logic [FRAC_BITS-1:0] s4_fx, s4_fy;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    tsb_bank u_bank (
      .clk   (clk),
      .we    (s3_we),
      .waddr (s3_index),
      .wdata (s3_texel),
      .raddr (s3_addr[b]),
      .rdata (rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid && s3_sample;
    end
    s4_fx <= s3_fx;
    s4_fy <= s3_fy;
  end

  // Stage 5: horizontal blend of both rows; stage 6: vertical blend.
  logic [N_W-1:0]    wx1, wx0, wy1, wy0;
  logic              s5_valid;
  logic [FRAC_BITS-1:0] s5_fy;
  logic [R_W-1:0]    s5_r0 [4];
  logic [R_W-1:0]    s5_r1 [4];
  logic [ACC_W-1:0]  acc [4];
  logic [CHAN_W-1:0] res [4];

  assign wx1 = {1'b0, s4_fx};
  assign wx0 = ONE_FX - wx1;
  assign wy1 = {1'b0, s5_fy};
  assign wy0 = ONE_FX - wy1;

  for (genvar c = 0; c < 4; c++) begin : g_chan
    always_ff @(posedge clk) begin
      s5_r0[c] <= R_W'(rd[0][c*CHAN_W +: CHAN_W]) * R_W'(wx0)
                + R_W'(rd[1][c*CHAN_W +: CHAN_W]) * R_W'(wx1);
      s5_r1[c] <= R_W'(rd[2][c*CHAN_W +: CHAN_W]) * R_W'(wx0)
                + R_W'(rd[3][c*CHAN_W +: CHAN_W]) * R_W'(wx1);
    end
    assign acc[c] = ACC_W'(s5_r0[c]) * ACC_W'(wy0) + ACC_W'(s5_r1[c]) * ACC_W'(wy1);
    always_ff @(posedge clk) begin
      res[c] <= acc[c][2*FRAC_BITS +: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
    end
    s5_fy <= s4_fy;
  end

  assign out_red   = res[0];
  assign out_green = res[1];
  assign out_blue  = res[2];
  assign out_alpha = res[3];

endmodule
`default_nettype wire

/* hw/rtl/tsb_checker.sv */
// Port-level checks for the texture sampler, bound to its top level.
`default_nettype none
module tsb_checker
  import tsb_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic cmd,
  input wire logic out_valid
);

  localparam int LAT = 6;

  // Every sample transaction produces exactly one result.
  a_sample_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_SAMPLE) |-> ##LAT out_valid)
    else $error("sample transaction did not produce a result");

  // A result only ever follows a sample transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(start && !busy && cmd == CMD_SAMPLE, LAT))
    else $error("result without a matching sample transaction");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result strobe after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("unit refused a transaction");

endmodule

bind texture_sampler_bilinear_unit tsb_checker u_tsb_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .cmd       (cmd),
  .out_valid (out_valid)
);
`default_nettype wire
